[hw/rtl/sha1_pkg.sv]
// SHA-1 engine package: round constants, initial chaining values, queue entry type.
// Used by every module of the sha1_hash_engine block. No dependencies.

package sha1_pkg;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  localparam logic [7:0] PadByte = 8'h80;

  // command codes of the input channel
  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // word queue between packer and round engine
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [31:0] word;
    logic        last_blk;  // final word of the final block of a message
  } q_entry_t;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0:    v = H0Init;
      3'd1:    v = H1Init;
      3'd2:    v = H2Init;
      3'd3:    v = H3Init;
      default: v = H4Init;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/sha1_in_if.sv]
// Input channel of the SHA-1 engine: command and message byte with valid/ready.
// Depends on nothing.

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

[hw/rtl/sha1_out_if.sv]
// Output channel of the SHA-1 engine: digest word and last flag with valid/ready.
// Depends on nothing.

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

[hw/rtl/sha1_front.sv]
// SHA-1 front end: packs message bytes into big-endian words and generates padding.
// Depends on sha1_pkg and sha1_in_if.

module sha1_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha1_in_if.sink           in_i,
  output logic              push_o,
  output sha1_pkg::q_entry_t push_data_o,
  input  logic              q_ready_i
);

  logic [63:0] cnt_q, cnt_d;
  logic [31:0] acc_q;
  logic [63:0] bits_q;
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        lenblk_q, lenblk_d;
  logic [3:0]  widx_q, widx_d;
  logic [1:0]  kbytes_q;

  logic        accept;
  logic        is_byte;
  logic        word_done;
  logic [31:0] pad_word;

  assign is_byte   = (in_i.cmd == sha1_pkg::CmdAbsorb);
  assign word_done = (cnt_q[1:0] == 2'd3);

  always_comb begin
    in_i.ready = 1'b0;
    if (!pad_q) begin
      in_i.ready = is_byte ? (!word_done || q_ready_i) : 1'b1;
    end
  end

  assign accept = in_i.valid && in_i.ready;

  // first padding word: bytes held so far, the marker byte, then zeros
  always_comb begin
    unique case (kbytes_q)
      2'd0:    pad_word = {sha1_pkg::PadByte, 24'h0};
      2'd1:    pad_word = {acc_q[7:0], sha1_pkg::PadByte, 16'h0};
      2'd2:    pad_word = {acc_q[15:0], sha1_pkg::PadByte, 8'h0};
      default: pad_word = {acc_q[23:0], sha1_pkg::PadByte};
    endcase
  end

  always_comb begin
    push_o               = 1'b0;
    push_data_o.word     = {acc_q[23:0], in_i.data_byte};
    push_data_o.last_blk = 1'b0;
    if (pad_q) begin
      push_o = q_ready_i;
      if (first_q) begin
        push_data_o.word = pad_word;
      end else if (lenblk_q && widx_q == 4'd14) begin
        push_data_o.word = bits_q[63:32];
      end else if (lenblk_q && widx_q == 4'd15) begin
        push_data_o.word = bits_q[31:0];
      end else begin
        push_data_o.word = 32'h0;
      end
      push_data_o.last_blk = lenblk_q && (widx_q == 4'd15);
    end else begin
      push_o = accept && is_byte && word_done;
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    pad_d    = pad_q;
    first_d  = first_q;
    lenblk_d = lenblk_q;
    widx_d   = widx_q;
    if (pad_q) begin
      if (q_ready_i) begin
        first_d = 1'b0;
        if (widx_q == 4'd15) begin
          if (lenblk_q) begin
            pad_d = 1'b0;
          end else begin
            lenblk_d = 1'b1;
            widx_d   = 4'd0;
          end
        end else begin
          widx_d = widx_q + 4'd1;
        end
      end
    end else if (accept) begin
      if (is_byte) begin
        cnt_d = cnt_q + 64'd1;
      end else begin
        cnt_d    = 64'd0;
        pad_d    = 1'b1;
        first_d  = 1'b1;
        widx_d   = cnt_q[5:2];
        // length fits in this block only if the marker lands before word 14
        lenblk_d = (cnt_q[5:2] < 4'd14);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 64'd0;
      pad_q    <= 1'b0;
      first_q  <= 1'b0;
      lenblk_q <= 1'b0;
      widx_q   <= 4'd0;
    end else begin
      cnt_q    <= cnt_d;
      pad_q    <= pad_d;
      first_q  <= first_d;
      lenblk_q <= lenblk_d;
      widx_q   <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_byte) begin
      acc_q <= {acc_q[23:0], in_i.data_byte};
    end
    if (accept && !is_byte) begin
      bits_q   <= {cnt_q[60:0], 3'b000};
      kbytes_q <= cnt_q[1:0];
    end
  end

endmodule

[hw/rtl/sha1_queue.sv]
// Short word queue between the SHA-1 front end and the round engine.
// Depends on sha1_pkg.

module sha1_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha1_pkg::q_entry_t push_data_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output sha1_pkg::q_entry_t pop_data_o
);

  sha1_pkg::q_entry_t mem_q [sha1_pkg::QDepth];
  logic [sha1_pkg::QAw-1:0] wptr_q, rptr_q;
  logic [sha1_pkg::QAw:0]   fill_q;

  localparam logic [sha1_pkg::QAw:0] Full = (sha1_pkg::QAw+1)'(sha1_pkg::QDepth);

  assign ready_o    = (fill_q != Full);
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      priority if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/sha1_back.sv]
// SHA-1 round engine: 80 rounds, one per cycle (rounds 0-15 wait for a queue word),
// chaining add, digest output. Depends on sha1_pkg and sha1_out_if.

module sha1_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sha1_pkg::q_entry_t q_data_i,
  output logic               q_pop_o,
  sha1_out_if.source         out_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRun  = 2'd1;
  localparam logic [1:0] SAdd  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        last_q;
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] w_q [16];

  logic        load_ph;
  logic        advance;
  logic [31:0] wsch, wt, f, k, t;

  assign load_ph = (rnd_q < 7'd16);
  assign advance = (state_q == SRun) && (!load_ph || q_valid_i);
  assign q_pop_o = (state_q == SRun) && load_ph && q_valid_i;

  // w_q[15] holds the newest schedule word
  always_comb begin
    wsch = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wsch = {wsch[30:0], wsch[31]};
    wt   = load_ph ? q_data_i.word : wsch;
  end

  always_comb begin
    priority if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = sha1_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = sha1_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = sha1_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = sha1_pkg::K3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    unique case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          state_d = SRun;
          rnd_d   = 7'd0;
        end
      end
      SRun: begin
        if (advance) begin
          rnd_d = rnd_q + 7'd1;
          if (rnd_q == 7'd79) begin
            state_d = SAdd;
          end
        end
      end
      SAdd: begin
        state_d = last_q ? SOut : SIdle;
        oidx_d  = 3'd0;
      end
      SOut: begin
        if (out_o.ready) begin
          if (oidx_q == 3'd4) begin
            state_d = SIdle;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rnd_q   <= 7'd0;
      oidx_q  <= 3'd0;
      last_q  <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h_q[i] <= sha1_pkg::h_init(3'(i));
      end
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      if (q_pop_o && rnd_q == 7'd15) begin
        last_q <= q_data_i.last_blk;
      end
      if (state_q == SAdd) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      // back to the initial chain once the final word is taken
      if (state_q == SOut && out_o.ready && oidx_q == 3'd4) begin
        for (int i = 0; i < 5; i++) begin
          h_q[i] <= sha1_pkg::h_init(3'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && q_valid_i) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (advance) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wt;
    end
  end

  assign out_o.valid       = (state_q == SOut);
  assign out_o.digest_word = h_q[oidx_q];
  assign out_o.last_word   = (oidx_q == 3'd4);

endmodule

[hw/rtl/sha1_hash_engine.sv]
// SHA-1 hash engine top level: byte packer, word queue and round engine.
// Depends on sha1_pkg, sha1_in_if, sha1_out_if, sha1_front, sha1_queue, sha1_back.
//
//   channel  dir  payload                        handshake
//   in_i     in   cmd, data_byte                 valid/ready
//   out_o    out  digest_word[31:0], last_word   valid/ready
//
// Bytes take one cycle each while input is not stalled; every fourth pushes a word
// into the four-word queue. A block takes a start step, 80 rounds and a chain add, but
// the packer runs only 19 bytes ahead, so word loading waits on it. A finish pushes
// 3 to 18 padding words, then five digest words leave one per cycle while out_o is
// ready. Reset gives the initial chain and a zero count. Input stalls while padding
// and when a full word meets a full queue; the engine holds while out_o stalls.

module sha1_hash_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha1_in_if.sink   in_i,
  sha1_out_if.source out_o
);

  logic               push;
  sha1_pkg::q_entry_t push_data;
  logic               q_ready;
  logic               q_valid;
  logic               q_pop;
  sha1_pkg::q_entry_t q_data;

  sha1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_ready_i   (q_ready)
  );

  sha1_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  sha1_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // no push into a full queue, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_ready)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("word popped from empty queue");

  // digest output and round loading never overlap
  a_out_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !q_pop)
    else $error("queue popped during digest output");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> !out_o.valid)
    else $error("digest output continued past last word");

endmodule
